[src/mscc_pkg.sv]
// Shared types, constants and the case template of the marching-squares contour cell.
`timescale 1ns / 1ps

package mscc_pkg;

   localparam int DEF_GRID_SIZE     = 1024;
   localparam int DEF_SAMPLE_WIDTH  = 16;
   localparam int DEF_FRACTION_BITS = 8;
   localparam int IDX_W             = 10;
   localparam int COORD_W           = 18;
   localparam int QUEUE_DEPTH       = 4;

   // Cell sides, numbered by their first corner.
   typedef enum logic [1:0] {
      SIDE_BOTTOM = 2'd0,
      SIDE_RIGHT  = 2'd1,
      SIDE_TOP    = 2'd2,
      SIDE_LEFT   = 2'd3
   } side_type;

   typedef struct packed {
      logic     has_pair;
      logic     two_pairs;
      side_type s0;
      side_type s1;
      side_type s2;
      side_type s3;
   } tmpl_type;

   function automatic tmpl_type template_lookup(input logic [3:0] code);
      tmpl_type t;
      t = '{has_pair: 1'b1, two_pairs: 1'b0, s0: SIDE_BOTTOM, s1: SIDE_BOTTOM,
            s2: SIDE_BOTTOM, s3: SIDE_BOTTOM};
      unique case (code)
         4'd1:  begin t.s0 = SIDE_LEFT;   t.s1 = SIDE_BOTTOM; end
         4'd2:  begin t.s0 = SIDE_BOTTOM; t.s1 = SIDE_RIGHT;  end
         4'd3:  begin t.s0 = SIDE_LEFT;   t.s1 = SIDE_RIGHT;  end
         4'd4:  begin t.s0 = SIDE_RIGHT;  t.s1 = SIDE_TOP;    end
         4'd5:  begin
            t.s0 = SIDE_LEFT;  t.s1 = SIDE_BOTTOM;
            t.s2 = SIDE_RIGHT; t.s3 = SIDE_TOP;
            t.two_pairs = 1'b1;
         end
         4'd6:  begin t.s0 = SIDE_BOTTOM; t.s1 = SIDE_TOP;    end
         4'd7:  begin t.s0 = SIDE_LEFT;   t.s1 = SIDE_TOP;    end
         4'd8:  begin t.s0 = SIDE_TOP;    t.s1 = SIDE_LEFT;   end
         4'd9:  begin t.s0 = SIDE_TOP;    t.s1 = SIDE_BOTTOM; end
         4'd10: begin
            t.s0 = SIDE_BOTTOM; t.s1 = SIDE_RIGHT;
            t.s2 = SIDE_TOP;    t.s3 = SIDE_LEFT;
            t.two_pairs = 1'b1;
         end
         4'd11: begin t.s0 = SIDE_TOP;    t.s1 = SIDE_RIGHT;  end
         4'd12: begin t.s0 = SIDE_RIGHT;  t.s1 = SIDE_LEFT;   end
         4'd13: begin t.s0 = SIDE_RIGHT;  t.s1 = SIDE_BOTTOM; end
         4'd14: begin t.s0 = SIDE_BOTTOM; t.s1 = SIDE_LEFT;   end
         default: t.has_pair = 1'b0;
      endcase
      return t;
   endfunction

endpackage

[src/marching_squares_contour_cell.sv]
// Top level of the marching-squares contour cell: front end, queue and back end.
`timescale 1ns / 1ps

// A cell is taken at a rising edge where start is high and busy is low. Cells
// that lie outside the grid or whose four corners are all on one side are taken
// and produce nothing. Every other cell yields one segment, or two for the
// saddle cases, and each segment appears on the rsp_ ports for exactly one
// cycle with rsp_valid high; the receiver has no way to hold results off, so
// it must take every one. The two segments of a saddle cell come in consecutive
// cycles and rsp_last_segment marks the final segment of each cell. The single
// result port sets the rate: the back end issues one segment per cycle. A taken
// cell passes through the queue and then the two pipelined dividers, each
// producing one quotient bit per stage, before its segments reach the
// registered rsp_ ports. Between front and back sits a four-entry queue of
// classified cells; busy is high while it is full, which happens only when
// the cells taken bring more than one segment per cycle on average, as with
// runs of saddle cells.
module marching_squares_contour_cell #(
   parameter int GRID_SIZE     = mscc_pkg::DEF_GRID_SIZE,
   parameter int SAMPLE_WIDTH  = mscc_pkg::DEF_SAMPLE_WIDTH,
   parameter int FRACTION_BITS = mscc_pkg::DEF_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mscc_pkg::IDX_W-1:0]      req_cell_x,
   input  logic [mscc_pkg::IDX_W-1:0]      req_cell_y,
   input  logic [SAMPLE_WIDTH-1:0]         req_phi_00,
   input  logic [SAMPLE_WIDTH-1:0]         req_phi_10,
   input  logic [SAMPLE_WIDTH-1:0]         req_phi_11,
   input  logic [SAMPLE_WIDTH-1:0]         req_phi_01,
   output logic                            rsp_valid,
   output logic [mscc_pkg::COORD_W-1:0]    rsp_start_x,
   output logic [mscc_pkg::COORD_W-1:0]    rsp_start_y,
   output logic [mscc_pkg::COORD_W-1:0]    rsp_end_x,
   output logic [mscc_pkg::COORD_W-1:0]    rsp_end_y,
   output logic                            rsp_last_segment
);
   import mscc_pkg::*;

   localparam int TW      = $bits(tmpl_type);
   localparam int ENTRY_W = 2 * IDX_W + 4 * SAMPLE_WIDTH + TW;

   // Corners in case-bit order: (x,y), (x+1,y), (x+1,y+1), (x,y+1).
   logic [3:0][SAMPLE_WIDTH-1:0] req_phi;
   tmpl_type                     front_tmpl;
   logic                         push, pop, queue_empty, queue_full;
   logic [ENTRY_W-1:0]           push_data, head;

   logic [IDX_W-1:0]             head_x, head_y;
   logic [3:0][SAMPLE_WIDTH-1:0] head_phi;
   tmpl_type                     head_tmpl;

   assign req_phi   = {req_phi_01, req_phi_11, req_phi_10, req_phi_00};
   assign push_data = {req_cell_x, req_cell_y, req_phi, front_tmpl};
   assign {head_x, head_y, head_phi, head_tmpl} = head;

   mscc_front #(.GRID_SIZE(GRID_SIZE), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .start      (start),
      .busy       (busy),
      .req_cell_x (req_cell_x),
      .req_cell_y (req_cell_y),
      .req_phi    (req_phi),
      .queue_full (queue_full),
      .push       (push),
      .tmpl       (front_tmpl)
   );

   mscc_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   mscc_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .cell_x           (head_x),
      .cell_y           (head_y),
      .phi              (head_phi),
      .tmpl             (head_tmpl),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_last_segment (rsp_last_segment)
   );

   a_busy_means_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> !push)
      else $error("cell written into the queue while busy");

endmodule

[src/mscc_front.sv]
// Front end: accepts cells, forms the case index and looks up the template.
`timescale 1ns / 1ps

module mscc_front #(
   parameter int GRID_SIZE    = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                    start,
   output logic                                    busy,
   input  logic [mscc_pkg::IDX_W-1:0]              req_cell_x,
   input  logic [mscc_pkg::IDX_W-1:0]              req_cell_y,
   input  logic [3:0][SAMPLE_WIDTH-1:0]            req_phi,
   input  logic                                    queue_full,
   output logic                                    push,
   output mscc_pkg::tmpl_type                      tmpl
);
   import mscc_pkg::*;

   logic [3:0] code;
   logic       in_grid;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         // A corner is inside when its sample is negative or zero.
         code[k] = req_phi[k][SAMPLE_WIDTH-1] | (req_phi[k] == '0);
      end
   end

   assign in_grid = (32'(req_cell_x) < 32'(GRID_SIZE - 1)) &&
                    (32'(req_cell_y) < 32'(GRID_SIZE - 1));
   assign tmpl    = template_lookup(code);
   assign busy    = queue_full;
   // Cells outside the grid and uniform cells are taken and dropped here.
   assign push    = start && !busy && in_grid && tmpl.has_pair;

endmodule

[src/mscc_fifo.sv]
// Short queue of classified cells between the front and back ends.
`timescale 1ns / 1ps

module mscc_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             empty,
   output logic             full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

endmodule

[src/mscc_div.sv]
// Pipelined restoring divider for the rounded, clamped crossing fraction.
`timescale 1ns / 1ps

module mscc_div #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                     clock,
   input  logic [SAMPLE_WIDTH-1:0]  a,
   input  logic [SAMPLE_WIDTH-1:0]  b,
   output logic [FRACTION_BITS:0]   frac
);
   localparam int SW = SAMPLE_WIDTH;
   localparam int F  = FRACTION_BITS;
   localparam int DW = SW + 1;
   localparam int RW = SW + F + 1;
   localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

   logic [DW-1:0] a_ext, b_ext, den, num, ud;
   logic          neg, zero_in;
   logic [RW-1:0] rem_in;

   logic [RW-1:0] r_ff [F+1];
   logic [DW-1:0] d_ff [F+1];
   logic [F:0]    q_ff [F+2];
   logic          z_ff [F+2];

   always_comb begin
      a_ext   = {a[SW-1], a};
      b_ext   = {b[SW-1], b};
      den     = a_ext - b_ext;
      neg     = den[DW-1];
      num     = neg ? (~a_ext + 1'b1) : a_ext;
      ud      = neg ? (~den + 1'b1) : den;
      // No crossing fraction when the difference vanishes or the numerator is not positive.
      zero_in = (den == '0) || num[DW-1] || (num == '0);
      // Numerator scaled by the fraction bits plus half the divisor rounds to nearest.
      rem_in  = {1'b0, num[SW-1:0], {F{1'b0}}} + {{(F + 1){1'b0}}, ud[DW-1:1]};
   end

   always_ff @(posedge clock) begin
      logic [RW:0] diff;
      logic [F:0]  qn;
      r_ff[0] <= rem_in;
      d_ff[0] <= ud;
      q_ff[0] <= '0;
      z_ff[0] <= zero_in;
      for (int k = 0; k <= F; k++) begin
         diff = {1'b0, r_ff[k]} - {1'b0, ({{F{1'b0}}, d_ff[k]} << (F - k))};
         qn = q_ff[k];
         qn[F - k] = !diff[RW];
         q_ff[k + 1] <= qn;
         z_ff[k + 1] <= z_ff[k];
         if (k < F) begin
            r_ff[k + 1] <= diff[RW] ? r_ff[k] : diff[RW-1:0];
            d_ff[k + 1] <= d_ff[k];
         end
      end
   end

   assign frac = z_ff[F+1] ? '0 : ((q_ff[F+1] > ONE) ? ONE : q_ff[F+1]);

endmodule

[src/mscc_back.sv]
// Back end: issues one segment a cycle through two dividers and places the crossings.
`timescale 1ns / 1ps

module mscc_back #(
   parameter int SAMPLE_WIDTH  = 16,
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_empty,
   input  logic [mscc_pkg::IDX_W-1:0]           cell_x,
   input  logic [mscc_pkg::IDX_W-1:0]           cell_y,
   input  logic [3:0][SAMPLE_WIDTH-1:0]         phi,
   input  mscc_pkg::tmpl_type                   tmpl,
   output logic                                 pop,
   output logic                                 rsp_valid,
   output logic [mscc_pkg::COORD_W-1:0]         rsp_start_x,
   output logic [mscc_pkg::COORD_W-1:0]         rsp_start_y,
   output logic [mscc_pkg::COORD_W-1:0]         rsp_end_x,
   output logic [mscc_pkg::COORD_W-1:0]         rsp_end_y,
   output logic                                 rsp_last_segment
);
   import mscc_pkg::*;

   localparam int F   = FRACTION_BITS;
   localparam int LAT = F + 2;
   localparam int CW  = (IDX_W + 1 + F > COORD_W) ? IDX_W + 1 + F : COORD_W;

   typedef struct packed {
      logic [IDX_W-1:0] cx;
      logic [IDX_W-1:0] cy;
      side_type         sa;
      side_type         sb;
      logic             last;
   } meta_type;

   logic     seg_sel_ff, seg_sel_in;
   logic     issue;
   side_type side_a, side_b;
   logic [1:0] na, nb;
   meta_type meta_in;
   logic [F:0] frac_a, frac_b;
   logic [2*COORD_W-1:0] pos_a, pos_b;

   logic     vld_ff  [LAT];
   meta_type meta_ff [LAT];

   logic                rsp_valid_ff;
   logic [COORD_W-1:0]  sx_ff, sy_ff, ex_ff, ey_ff;
   logic                last_ff;

   function automatic logic [2*COORD_W-1:0] place(input side_type sd,
                                                  input logic [IDX_W-1:0] cx,
                                                  input logic [IDX_W-1:0] cy,
                                                  input logic [F:0] s);
      logic [CW-1:0] bx, by, sv, one;
      bx  = CW'(cx) << F;
      by  = CW'(cy) << F;
      sv  = CW'(s);
      one = CW'(1) << F;
      unique case (sd)
         SIDE_BOTTOM: bx = bx + sv;
         SIDE_RIGHT:  begin bx = bx + one; by = by + sv; end
         SIDE_TOP:    begin bx = bx + one - sv; by = by + one; end
         SIDE_LEFT:   by = by + one - sv;
      endcase
      return {bx[COORD_W-1:0], by[COORD_W-1:0]};
   endfunction

   always_comb begin
      issue   = !queue_empty;
      side_a  = seg_sel_ff ? tmpl.s2 : tmpl.s0;
      side_b  = seg_sel_ff ? tmpl.s3 : tmpl.s1;
      na      = 2'(side_a) + 2'd1;
      nb      = 2'(side_b) + 2'd1;
      meta_in = '{cx: cell_x, cy: cell_y, sa: side_a, sb: side_b,
                  last: seg_sel_ff || !tmpl.two_pairs};
      pop     = issue && meta_in.last;
      seg_sel_in = seg_sel_ff;
      if (issue) begin
         seg_sel_in = !meta_in.last;
      end
   end

   mscc_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(F)) u_div_a (
      .clock (clock),
      .a     (phi[side_a]),
      .b     (phi[na]),
      .frac  (frac_a)
   );

   mscc_div #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .FRACTION_BITS(F)) u_div_b (
      .clock (clock),
      .a     (phi[side_b]),
      .b     (phi[nb]),
      .frac  (frac_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         seg_sel_ff   <= seg_sel_in;
         vld_ff[0]    <= issue;
         for (int k = 1; k < LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   assign pos_a = place(meta_ff[LAT-1].sa, meta_ff[LAT-1].cx, meta_ff[LAT-1].cy, frac_a);
   assign pos_b = place(meta_ff[LAT-1].sb, meta_ff[LAT-1].cx, meta_ff[LAT-1].cy, frac_b);

   always_ff @(posedge clock) begin
      meta_ff[0] <= meta_in;
      for (int k = 1; k < LAT; k++) begin
         meta_ff[k] <= meta_ff[k-1];
      end
      {sx_ff, sy_ff} <= pos_a;
      {ex_ff, ey_ff} <= pos_b;
      last_ff        <= meta_ff[LAT-1].last;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_start_x      = sx_ff;
   assign rsp_start_y      = sy_ff;
   assign rsp_end_x        = ex_ff;
   assign rsp_end_y        = ey_ff;
   assign rsp_last_segment = last_ff;

   a_pair_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_segment |=> rsp_valid)
      else $error("second segment of a saddle cell did not follow the first");

   a_second_has_entry: assert property (@(posedge clock) disable iff (reset)
      seg_sel_ff |-> !queue_empty && tmpl.two_pairs)
      else $error("second segment pending without a two-pair cell at the head");

endmodule

[verif/tb.sv]
// Self-checking testbench for the marching-squares contour cell.
`timescale 1ns / 1ps

module tb;
   import mscc_pkg::*;

   localparam int FRAC     = DEF_FRACTION_BITS;
   localparam int GRID     = DEF_GRID_SIZE;
   localparam int ONE_FRAC = 1 << FRAC;
   localparam int N_RANDOM = 1130;

   // One grid cell as it goes into the block; phi[k] is the sample at corner k,
   // with corners numbered 0 = (x,y), 1 = (x+1,y), 2 = (x+1,y+1), 3 = (x,y+1).
   typedef struct packed {
      logic [IDX_W-1:0]                  x;
      logic [IDX_W-1:0]                  y;
      logic [3:0][DEF_SAMPLE_WIDTH-1:0]  phi;
   } cell_type;

   // One contour segment as it leaves the block.
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic               last;
   } seg_type;

   // The scoreboard predicts the segments of every accepted cell and checks the
   // segments that come out against them, strictly in order.
   class segment_board;
      seg_type expected_segs[$];
      int      mismatches = 0;

      // Fraction along a side from a corner with sample a to one with sample b,
      // rounded to nearest with halves up and clamped to one.
      function automatic int unsigned crossing_frac(int a, int b);
         int num;
         int den;
         int unsigned s;
         num = a;
         den = a - b;
         if (den == 0) return 0;
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (num <= 0) return 0;
         s = ((num << FRAC) + den / 2) / den;
         return (s > ONE_FRAC) ? ONE_FRAC : s;
      endfunction

      // Crossing point on one side of the cell; each side runs from its own
      // corner to the next corner counterclockwise.
      function automatic void side_point(side_type sd, int cx, int cy, int phi[4],
                                         output logic [COORD_W-1:0] px,
                                         output logic [COORD_W-1:0] py);
         int unsigned s;
         int          k0;
         int          x;
         int          y;
         k0 = int'(sd);
         s  = crossing_frac(phi[k0], phi[(k0 + 1) % 4]);
         case (sd)
            SIDE_BOTTOM: begin x = (cx << FRAC) + s;       y = cy << FRAC; end
            SIDE_RIGHT:  begin x = (cx + 1) << FRAC;       y = (cy << FRAC) + s; end
            SIDE_TOP:    begin x = ((cx + 1) << FRAC) - s; y = (cy + 1) << FRAC; end
            default:     begin x = cx << FRAC;             y = ((cy + 1) << FRAC) - s; end
         endcase
         px = x[COORD_W-1:0];
         py = y[COORD_W-1:0];
      endfunction

      // Note one accepted cell and queue the segments it must produce.
      function void note_cell(cell_type c);
         int       phi[4];
         int       cx;
         int       cy;
         int       n_pairs;
         side_type sides[4];
         seg_type  sg;
         logic [3:0] code;
         cx = c.x;
         cy = c.y;
         if (cx >= GRID - 1 || cy >= GRID - 1) return;
         for (int k = 0; k < 4; k++) begin
            phi[k]  = int'($signed(c.phi[k]));
            code[k] = (phi[k] <= 0);
         end
         n_pairs = 1;
         sides   = '{SIDE_BOTTOM, SIDE_BOTTOM, SIDE_BOTTOM, SIDE_BOTTOM};
         case (code)
            4'd1:  begin sides[0] = SIDE_LEFT;   sides[1] = SIDE_BOTTOM; end
            4'd2:  begin sides[0] = SIDE_BOTTOM; sides[1] = SIDE_RIGHT;  end
            4'd3:  begin sides[0] = SIDE_LEFT;   sides[1] = SIDE_RIGHT;  end
            4'd4:  begin sides[0] = SIDE_RIGHT;  sides[1] = SIDE_TOP;    end
            4'd5:  begin
               sides   = '{SIDE_LEFT, SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP};
               n_pairs = 2;
            end
            4'd6:  begin sides[0] = SIDE_BOTTOM; sides[1] = SIDE_TOP;    end
            4'd7:  begin sides[0] = SIDE_LEFT;   sides[1] = SIDE_TOP;    end
            4'd8:  begin sides[0] = SIDE_TOP;    sides[1] = SIDE_LEFT;   end
            4'd9:  begin sides[0] = SIDE_TOP;    sides[1] = SIDE_BOTTOM; end
            4'd10: begin
               sides   = '{SIDE_BOTTOM, SIDE_RIGHT, SIDE_TOP, SIDE_LEFT};
               n_pairs = 2;
            end
            4'd11: begin sides[0] = SIDE_TOP;    sides[1] = SIDE_RIGHT;  end
            4'd12: begin sides[0] = SIDE_RIGHT;  sides[1] = SIDE_LEFT;   end
            4'd13: begin sides[0] = SIDE_RIGHT;  sides[1] = SIDE_BOTTOM; end
            4'd14: begin sides[0] = SIDE_BOTTOM; sides[1] = SIDE_LEFT;   end
            default: n_pairs = 0;
         endcase
         for (int p = 0; p < n_pairs; p++) begin
            side_point(sides[2*p],     cx, cy, phi, sg.start_x, sg.start_y);
            side_point(sides[2*p + 1], cx, cy, phi, sg.end_x,   sg.end_y);
            sg.last = (p == n_pairs - 1);
            expected_segs.insert(expected_segs.size(), sg);
         end
      endfunction

      // Compare one segment from the block with the oldest one still expected.
      function void check_segment(seg_type got);
         seg_type want;
         if (expected_segs.size() == 0) begin
            $display("%0t: segment expected none actual %h", $time, got);
            mismatches++;
            return;
         end
         want = expected_segs.pop_front();
         if (got.start_x !== want.start_x) begin
            $display("%0t: start_x expected %h actual %h", $time, want.start_x, got.start_x);
            mismatches++;
         end
         if (got.start_y !== want.start_y) begin
            $display("%0t: start_y expected %h actual %h", $time, want.start_y, got.start_y);
            mismatches++;
         end
         if (got.end_x !== want.end_x) begin
            $display("%0t: end_x expected %h actual %h", $time, want.end_x, got.end_x);
            mismatches++;
         end
         if (got.end_y !== want.end_y) begin
            $display("%0t: end_y expected %h actual %h", $time, want.end_y, got.end_y);
            mismatches++;
         end
         if (got.last !== want.last) begin
            $display("%0t: last_segment expected %b actual %b", $time, want.last, got.last);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_segs.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [IDX_W-1:0]            req_cell_x = '0;
   logic [IDX_W-1:0]            req_cell_y = '0;
   logic [DEF_SAMPLE_WIDTH-1:0] req_phi_00 = '0;
   logic [DEF_SAMPLE_WIDTH-1:0] req_phi_10 = '0;
   logic [DEF_SAMPLE_WIDTH-1:0] req_phi_11 = '0;
   logic [DEF_SAMPLE_WIDTH-1:0] req_phi_01 = '0;
   logic                        rsp_valid;
   logic [COORD_W-1:0]          rsp_start_x;
   logic [COORD_W-1:0]          rsp_start_y;
   logic [COORD_W-1:0]          rsp_end_x;
   logic [COORD_W-1:0]          rsp_end_y;
   logic                        rsp_last_segment;

   segment_board sb = new();
   int           sender_idle_pct = 0;

   marching_squares_contour_cell u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_phi_00       (req_phi_00),
      .req_phi_10       (req_phi_10),
      .req_phi_11       (req_phi_11),
      .req_phi_01       (req_phi_01),
      .rsp_valid        (rsp_valid),
      .rsp_start_x      (rsp_start_x),
      .rsp_start_y      (rsp_start_y),
      .rsp_end_x        (rsp_end_x),
      .rsp_end_y        (rsp_end_y),
      .rsp_last_segment (rsp_last_segment)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard limit on the run. The slowest correct run is about 1150 cells of at
   // most two segments each, with the sender idle in at most about half the
   // cycles, plus the pipeline latency. Two milliseconds is far above that.
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Results cannot be held off, so every cycle with rsp_valid high carries a
   // segment that is taken at the closing edge. Sampling at the edge reads the
   // values from before the block's own updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.check_segment('{start_x: rsp_start_x, start_y: rsp_start_y,
                            end_x: rsp_end_x, end_y: rsp_end_y,
                            last: rsp_last_segment});
      end
   end

   function automatic cell_type make_cell(int x, int y, int p00, int p10, int p11, int p01);
      cell_type c;
      c.x      = x[IDX_W-1:0];
      c.y      = y[IDX_W-1:0];
      c.phi[0] = p00[DEF_SAMPLE_WIDTH-1:0];
      c.phi[1] = p10[DEF_SAMPLE_WIDTH-1:0];
      c.phi[2] = p11[DEF_SAMPLE_WIDTH-1:0];
      c.phi[3] = p01[DEF_SAMPLE_WIDTH-1:0];
      return c;
   endfunction

   // A random sample: mostly the full range, often small values around zero
   // so that zero-valued corners and short crossings turn up, and sometimes
   // the extremes of the range.
   function automatic int rand_sample();
      int pick;
      int ext[5] = '{-32768, 32767, 0, -1, 1};
      pick = $urandom_range(0, 9);
      if (pick == 0) return ext[$urandom_range(0, 4)];
      if (pick <= 3) return $urandom_range(0, 16) - 8;
      return int'($signed(16'($urandom)));
   endfunction

   // A random cell index: mostly inside the grid, now and then on the last row
   // or column, which lies outside it and must produce nothing.
   function automatic int rand_index();
      if ($urandom_range(0, 19) == 0) return GRID - 1;
      return $urandom_range(0, GRID - 2);
   endfunction

   // Present one item and hold it until the block takes it. Before the item the
   // sender goes quiet in each cycle with the current idle percentage; while
   // quiet, req_cell_x and req_phi_11 carry junk so that nothing is taken from
   // them by accident.
   task automatic send_cell(input cell_type c);
      while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
         start      <= 1'b0;
         req_cell_x <= IDX_W'($urandom);
         req_phi_11 <= 16'($urandom);
         @(posedge clock);
      end
      start      <= 1'b1;
      req_cell_x <= c.x;
      req_cell_y <= c.y;
      req_phi_00 <= c.phi[0];
      req_phi_10 <= c.phi[1];
      req_phi_11 <= c.phi[2];
      req_phi_01 <= c.phi[3];
      do @(posedge clock); while (busy !== 1'b0);
      sb.note_cell(c);
   endtask

   initial begin
      int in_vals[4]  = '{-32768, 0, -1, -300};
      int out_vals[4] = '{32767, 1, 200, 9};
      int v[4];
      int wait_cycles;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cells. First every corner pattern, the two uniform ones and
      // both saddles among them, with extreme and zero samples on the corners.
      for (int k = 0; k < 16; k++) begin
         for (int i = 0; i < 4; i++) begin
            v[i] = k[i] ? in_vals[(k + i) % 4] : out_vals[(k + i) % 4];
         end
         send_cell(make_cell(k * 64, GRID - 2 - k * 64, v[0], v[1], v[2], v[3]));
      end
      // Cells on the last column and last row lie outside the grid.
      send_cell(make_cell(GRID - 1, 5, -10, 10, -10, 10));
      send_cell(make_cell(7, GRID - 1, 10, -10, 10, -10));
      send_cell(make_cell(GRID - 1, GRID - 1, -1, 1, 1, 1));
      // The far corner of the grid with full-range samples on a saddle.
      send_cell(make_cell(GRID - 2, GRID - 2, 32767, -32768, 32767, -32768));
      // A zero sample on the inside end puts the crossing on the corner, and
      // a half-way split and a one-in-three split check the rounding.
      send_cell(make_cell(0, 0, 0, 5, 5, 5));
      send_cell(make_cell(3, 4, 1, -1, -1, 1));
      send_cell(make_cell(9, 2, -1, 2, 2, -1));
      send_cell(make_cell(100, 200, 1, -511, -511, 1));

      // Random cells in three phases: the sender idles often, then very often,
      // then never. The receiver cannot stall, so only the sender idles.
      for (int ph = 0; ph < 3; ph++) begin
         sender_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 48 : 0;
         for (int n = 0; n < N_RANDOM / 3; n++) begin
            send_cell(make_cell(rand_index(), rand_index(), rand_sample(), rand_sample(),
                                rand_sample(), rand_sample()));
         end
      end
      start <= 1'b0;

      // Drain every outstanding segment, then give the pipeline a further
      // stretch to show any segment that should not be there.
      while (sb.pending() != 0) @(posedge clock);
      wait_cycles = FRAC + 3 + 20;
      repeat (wait_cycles) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

[marching_squares_contour_cell.f]
src/mscc_pkg.sv
src/mscc_front.sv
src/mscc_fifo.sv
src/mscc_div.sv
src/mscc_back.sv
src/marching_squares_contour_cell.sv
verif/tb.sv
